[design/i2cmbs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
package i2cmbs_pkg;

	// Command codes carried in the opcode field.
	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_WRITE    = 3'd2,
		OP_WAIT_ACK = 3'd3,
		OP_READ     = 3'd4
	} opcode_t;

	// Sequencer phases, one-hot coded.
	typedef enum logic [15:0] {
		PH_IDLE     = 16'h0001,
		PH_S_SDALOW = 16'h0002,
		PH_S_SCLLOW = 16'h0004,
		PH_T_HIGH   = 16'h0008,
		PH_FINISH   = 16'h0010,
		PH_W_DATA   = 16'h0020,
		PH_W_SCLH   = 16'h0040,
		PH_W_SCLL   = 16'h0080,
		PH_A_SCLH   = 16'h0100,
		PH_A_POLL   = 16'h0200,
		PH_R_SCLH   = 16'h0400,
		PH_R_SAMPLE = 16'h0800,
		PH_R_SCLL   = 16'h1000,
		PH_K_SETUP  = 16'h2000,
		PH_K_SCLH   = 16'h4000,
		PH_K_SCLL   = 16'h8000
	} phase_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_HALF_PERIOD = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} reg_index_t;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
	localparam int          TDATA_W         = 16;

endpackage

[design/i2c_master_bit_sequencer_unit.sv]
// Top level of the I2C master bit sequencer: tick-driven bus sequencer with output skid stage.
//
// Usage: every transfer on the slave stream is one tick of the bus sequencer. It carries
// a command-valid flag, an opcode (start, stop, write byte, wait for acknowledge, read
// byte), the byte to send, the acknowledge choice for reads and the sampled SDA level.
// A command is taken only while the sequencer is idle; otherwise the flag is ignored.
// Every tick produces exactly one result transfer on the master stream with the SCL
// level, the SDA level and output enable, busy, a done pulse, the received byte and
// the acknowledge failure flag.
// The result of a tick is registered in the output register, or in the skid register when the output is held.
// Throughput: one tick per clock cycle while s_axis_tready is high; the next-state logic is a
// single pass from the sequencer registers and the incoming tick to the result register.
// Stall: when the receiver holds tready low, one further result is kept in a skid
// register, after which s_axis_tready drops until the receiver takes a result.
// Reset: arst_n clears the sequencer to idle with SCL and SDA high and SDA driven,
// restores half_period to 5 and ack_timeout to 250, and empties the output stage.
// Users write configuration on cfg_we/cfg_index/cfg_wdata while the block is idle; unenforced.
module i2c_master_bit_sequencer_unit
	import i2cmbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_wdata,
	// Tick input stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [0] cmd_valid, [3:1] opcode, [11:4] tx_byte, [12] send_ack, [13] sda_in, [15:14] zero
	input  logic [TDATA_W-1:0]   s_axis_tdata,
	// Result output stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res, [12:5] rx_byte,
	// [13] ack_failed, [15:14] zero
	output logic [TDATA_W-1:0]   m_axis_tdata
);

	// Configuration registers.
	logic [15:0] half_period_q;
	logic [7:0]  ack_timeout_q;

	// Sequencer state.
	phase_t      phase_q, phase_d;
	logic [2:0]  cmd_q, cmd_d;
	logic [15:0] delay_q, delay_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  poll_q, poll_d;
	logic        ack_choice_q, ack_choice_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        sda_en_q, sda_en_d;

	// Output stage and skid register.
	logic                 out_valid_q, skid_valid_q;
	logic [TDATA_W-1:0]   out_data_q, skid_data_q;

	// Unpacked input fields.
	logic        in_cmd_valid;
	opcode_t     in_opcode;
	logic [7:0]  in_tx_byte;
	logic        in_send_ack;
	logic        in_sda;

	logic        in_fire, out_fire;
	logic [15:0] delay_load;
	logic [3:0]  bit_count_inc;
	logic        res_done, res_fail;
	logic [7:0]  res_rx;
	logic [TDATA_W-1:0] res_data;

	assign in_cmd_valid = s_axis_tdata[0];
	assign in_opcode    = opcode_t'(s_axis_tdata[3:1]);
	assign in_tx_byte   = s_axis_tdata[11:4];
	assign in_send_ack  = s_axis_tdata[12];
	assign in_sda       = s_axis_tdata[13];

	assign s_axis_tready = !skid_valid_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A half period of zero behaves as one tick.
	assign delay_load    = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
	assign bit_count_inc = bit_count_q + 4'd1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_HALF_PERIOD: half_period_q <= cfg_wdata;
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Next-state logic for one tick.
	always_comb begin
		phase_d      = phase_q;
		cmd_d        = cmd_q;
		delay_d      = delay_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		poll_d       = poll_q;
		ack_choice_d = ack_choice_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		sda_en_d     = sda_en_q;
		res_done     = 1'b0;
		res_rx       = 8'd0;
		res_fail     = 1'b0;

		if (phase_q == PH_IDLE) begin
			// Accept a known command; its first edges are driven on this tick.
			if (in_cmd_valid && (in_opcode inside {[OP_START:OP_READ]})) begin
				cmd_d   = in_opcode;
				delay_d = delay_load;
				case (in_opcode)
					OP_START: begin
						sda_en_d = 1'b1;
						sda_d    = 1'b1;
						scl_d    = 1'b1;
						phase_d  = PH_S_SDALOW;
					end
					OP_STOP: begin
						sda_en_d = 1'b1;
						scl_d    = 1'b0;
						sda_d    = 1'b0;
						phase_d  = PH_T_HIGH;
					end
					OP_WRITE: begin
						sda_en_d    = 1'b1;
						scl_d       = 1'b0;
						shift_d     = in_tx_byte;
						bit_count_d = 4'd0;
						phase_d     = PH_W_DATA;
					end
					OP_WAIT_ACK: begin
						sda_en_d = 1'b0;
						sda_d    = 1'b1;
						poll_d   = 8'd0;
						phase_d  = PH_A_SCLH;
					end
					default: begin
						sda_en_d     = 1'b0;
						shift_d      = 8'd0;
						bit_count_d  = 4'd0;
						ack_choice_d = in_send_ack;
						scl_d        = 1'b0;
						phase_d      = PH_R_SCLH;
					end
				endcase
			end
		end else if (delay_q > 16'd1) begin
			delay_d = delay_q - 16'd1;
		end else begin
			// Delay expired: perform the action of the current phase.
			delay_d = 16'd0;
			case (phase_q)
				PH_S_SDALOW: begin
					sda_d   = 1'b0;
					delay_d = delay_load;
					phase_d = PH_S_SCLLOW;
				end
				PH_S_SCLLOW: begin
					scl_d    = 1'b0;
					res_done = 1'b1;
					phase_d  = PH_IDLE;
				end
				PH_T_HIGH: begin
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					delay_d = delay_load;
					phase_d = PH_FINISH;
				end
				PH_FINISH: begin
					res_fail = (cmd_q == OP_WAIT_ACK);
					res_done = 1'b1;
					phase_d  = PH_IDLE;
				end
				PH_W_DATA: begin
					sda_d   = shift_q[7];
					shift_d = {shift_q[6:0], 1'b0};
					delay_d = delay_load;
					phase_d = PH_W_SCLH;
				end
				PH_W_SCLH: begin
					scl_d   = 1'b1;
					delay_d = delay_load;
					phase_d = PH_W_SCLL;
				end
				PH_W_SCLL: begin
					scl_d       = 1'b0;
					bit_count_d = bit_count_inc;
					delay_d     = delay_load;
					phase_d     = bit_count_inc[3] ? PH_FINISH : PH_W_DATA;
				end
				PH_A_SCLH: begin
					scl_d   = 1'b1;
					delay_d = delay_load;
					phase_d = PH_A_POLL;
				end
				PH_A_POLL: begin
					if (!in_sda) begin
						scl_d    = 1'b0;
						res_done = 1'b1;
						phase_d  = PH_IDLE;
					end else if (poll_q >= ack_timeout_q) begin
						// Timed out: send a stop and report the failure at its end.
						sda_en_d = 1'b1;
						scl_d    = 1'b0;
						sda_d    = 1'b0;
						delay_d  = delay_load;
						phase_d  = PH_T_HIGH;
					end else begin
						poll_d = poll_q + 8'd1;
					end
				end
				PH_R_SCLL: begin
					scl_d   = 1'b0;
					delay_d = delay_load;
					phase_d = PH_R_SCLH;
				end
				PH_R_SCLH: begin
					scl_d   = 1'b1;
					delay_d = delay_load;
					phase_d = PH_R_SAMPLE;
				end
				PH_R_SAMPLE: begin
					shift_d     = {shift_q[6:0], in_sda};
					bit_count_d = bit_count_inc;
					delay_d     = delay_load;
					phase_d     = bit_count_inc[3] ? PH_K_SETUP : PH_R_SCLL;
				end
				PH_K_SETUP: begin
					scl_d    = 1'b0;
					sda_en_d = 1'b1;
					sda_d    = !ack_choice_q;
					delay_d  = delay_load;
					phase_d  = PH_K_SCLH;
				end
				PH_K_SCLH: begin
					scl_d   = 1'b1;
					delay_d = delay_load;
					phase_d = PH_K_SCLL;
				end
				PH_K_SCLL: begin
					scl_d    = 1'b0;
					res_rx   = shift_q;
					res_done = 1'b1;
					phase_d  = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Result word for this tick.
	assign res_data = {2'b00, res_fail, res_rx, res_done, (phase_d != PH_IDLE),
		sda_en_d, sda_d, scl_d};

	// Sequencer registers advance once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cmd_q        <= 3'd0;
			delay_q      <= 16'd0;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			poll_q       <= 8'd0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			sda_en_q     <= 1'b1;
		end else if (in_fire) begin
			phase_q      <= phase_d;
			cmd_q        <= cmd_d;
			delay_q      <= delay_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			poll_q       <= poll_d;
			ack_choice_q <= ack_choice_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			sda_en_q     <= sda_en_d;
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= res_data;
			end
		end else if (in_fire) begin
			skid_data_q <= res_data;
		end
	end

	// The skid register only fills behind a held result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result with the output register empty");

	// A tick taken while a result waits lands in the skid register.
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_valid_q && !m_axis_tready) |=> skid_valid_q)
		else $error("result of a stalled tick was not kept");

	// The done tick reports the sequencer idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[4]) |-> !out_data_q[3])
		else $error("done result also reports busy");

	// The bit counter never passes one byte.
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= 4'd8)
		else $error("bit counter beyond eight");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master bit sequencer: tick stimulus, line prediction, checks.
module tb_top
	import i2cmbs_pkg::*;
();

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CHUNK_TICKS  = 36;

	// How the testbench drives the SDA input while a command runs.
	typedef enum int {
		SDA_RAND,
		SDA_HIGH,
		SDA_LOW
	} sda_drive_t;

	// One tick as it travels on the input stream, lowest bit last in the list.
	typedef struct packed {
		logic       sda_in;
		logic       send_ack;
		logic [7:0] tx_byte;
		logic [2:0] opcode;
		logic       cmd_valid;
	} tick_t;

	// Line levels and status of one tick as they travel on the output stream.
	typedef struct packed {
		logic       ack_failed;
		logic [7:0] rx_byte;
		logic       done;
		logic       busy;
		logic       sda_oe;
		logic       sda_out;
		logic       scl;
	} lines_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_we        = 1'b0;
	logic               cfg_index     = REG_HALF_PERIOD;
	logic [15:0]        cfg_wdata     = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	// [0] cmd_valid, [3:1] opcode, [11:4] tx_byte, [12] send_ack, [13] sda_in, [15:14] zero
	logic [TDATA_W-1:0] s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res, [12:5] rx_byte,
	// [13] ack_failed, [15:14] zero
	logic [TDATA_W-1:0] m_axis_tdata;

	// Predicted sequencer state and register copies.
	phase_t      seq_phase;
	logic [2:0]  seq_cmd;
	logic [15:0] seq_delay;
	logic [3:0]  seq_bits;
	logic [7:0]  seq_shift;
	logic [7:0]  seq_polls;
	logic        seq_ack_sel;
	logic        seq_scl;
	logic        seq_sda;
	logic        seq_oe;
	logic [15:0] half_period_q;
	logic [7:0]  ack_timeout_q;

	lines_t predicted_lines_q[$];
	lines_t seen_lines;
	lines_t want_lines;

	int mismatch_count  = 0;
	int results_checked = 0;
	int commands_issued = 0;
	int ack_failures    = 0;
	int config_writes   = 0;
	int counted_ticks   = 0;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int hold_left       = 0;
	int idle_cycles     = 0;
	bit hold_req        = 1'b0;

	i2c_master_bit_sequencer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Predictor: load the delay counter and move to the next phase.
	task automatic arm_delay(input phase_t nxt);
		seq_delay = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
		seq_phase = nxt;
	endtask

	// Predictor: SCL and SDA low, then the stop edges follow.
	task automatic begin_stop();
		seq_oe  = 1'b1;
		seq_scl = 1'b0;
		seq_sda = 1'b0;
		arm_delay(PH_T_HIGH);
	endtask

	task automatic reset_prediction();
		half_period_q = HALF_PERIOD_RST;
		ack_timeout_q = ACK_TIMEOUT_RST;
		seq_phase     = PH_IDLE;
		seq_cmd       = '0;
		seq_delay     = '0;
		seq_bits      = '0;
		seq_shift     = '0;
		seq_polls     = '0;
		seq_ack_sel   = 1'b0;
		seq_scl       = 1'b1;
		seq_sda       = 1'b1;
		seq_oe        = 1'b1;
	endtask

	// Advance the predicted sequencer by one tick and work out the lines it drives.
	task automatic step_bus_sequencer(input tick_t t, output lines_t r);
		r = '0;
		if (seq_phase == PH_IDLE) begin
			if (t.cmd_valid && t.opcode <= OP_READ) begin
				seq_cmd = t.opcode;
				case (t.opcode)
					OP_START: begin
						seq_oe  = 1'b1;
						seq_sda = 1'b1;
						seq_scl = 1'b1;
						arm_delay(PH_S_SDALOW);
					end
					OP_STOP: begin
						begin_stop();
					end
					OP_WRITE: begin
						seq_oe    = 1'b1;
						seq_scl   = 1'b0;
						seq_shift = t.tx_byte;
						seq_bits  = '0;
						arm_delay(PH_W_DATA);
					end
					OP_WAIT_ACK: begin
						seq_oe    = 1'b0;
						seq_sda   = 1'b1;
						seq_polls = '0;
						arm_delay(PH_A_SCLH);
					end
					default: begin
						seq_oe      = 1'b0;
						seq_shift   = '0;
						seq_bits    = '0;
						seq_ack_sel = t.send_ack;
						seq_scl     = 1'b0;
						arm_delay(PH_R_SCLH);
					end
				endcase
			end
		end else if (seq_delay > 16'd1) begin
			seq_delay = seq_delay - 16'd1;
		end else begin
			seq_delay = '0;
			case (seq_phase)
				PH_S_SDALOW: begin
					seq_sda = 1'b0;
					arm_delay(PH_S_SCLLOW);
				end
				PH_S_SCLLOW: begin
					seq_scl   = 1'b0;
					r.done    = 1'b1;
					seq_phase = PH_IDLE;
				end
				PH_T_HIGH: begin
					seq_scl = 1'b1;
					seq_sda = 1'b1;
					arm_delay(PH_FINISH);
				end
				PH_FINISH: begin
					r.ack_failed = (seq_cmd == OP_WAIT_ACK);
					r.done       = 1'b1;
					seq_phase    = PH_IDLE;
				end
				PH_W_DATA: begin
					seq_sda   = seq_shift[7];
					seq_shift = {seq_shift[6:0], 1'b0};
					arm_delay(PH_W_SCLH);
				end
				PH_W_SCLH: begin
					seq_scl = 1'b1;
					arm_delay(PH_W_SCLL);
				end
				PH_W_SCLL: begin
					seq_scl  = 1'b0;
					seq_bits = seq_bits + 4'd1;
					arm_delay((seq_bits >= 4'd8) ? PH_FINISH : PH_W_DATA);
				end
				PH_A_SCLH: begin
					seq_scl = 1'b1;
					arm_delay(PH_A_POLL);
				end
				PH_A_POLL: begin
					// Low SDA is the acknowledge; a high poll beyond the tolerance ends in a stop.
					if (!t.sda_in) begin
						seq_scl   = 1'b0;
						r.done    = 1'b1;
						seq_phase = PH_IDLE;
					end else if (seq_polls >= ack_timeout_q) begin
						begin_stop();
					end else begin
						seq_polls = seq_polls + 8'd1;
					end
				end
				PH_R_SCLL: begin
					seq_scl = 1'b0;
					arm_delay(PH_R_SCLH);
				end
				PH_R_SCLH: begin
					seq_scl = 1'b1;
					arm_delay(PH_R_SAMPLE);
				end
				PH_R_SAMPLE: begin
					seq_shift = {seq_shift[6:0], t.sda_in};
					seq_bits  = seq_bits + 4'd1;
					arm_delay((seq_bits >= 4'd8) ? PH_K_SETUP : PH_R_SCLL);
				end
				PH_K_SETUP: begin
					seq_scl = 1'b0;
					seq_oe  = 1'b1;
					seq_sda = ~seq_ack_sel;
					arm_delay(PH_K_SCLH);
				end
				PH_K_SCLH: begin
					seq_scl = 1'b1;
					arm_delay(PH_K_SCLL);
				end
				PH_K_SCLL: begin
					seq_scl   = 1'b0;
					r.rx_byte = seq_shift;
					r.done    = 1'b1;
					seq_phase = PH_IDLE;
				end
				default: begin
					seq_phase = PH_IDLE;
				end
			endcase
		end
		r.scl     = seq_scl;
		r.sda_out = seq_sda;
		r.sda_oe  = seq_oe;
		r.busy    = (seq_phase != PH_IDLE);
	endtask

	function automatic logic sda_for(input sda_drive_t mode);
		case (mode)
			SDA_HIGH: return 1'b1;
			SDA_LOW:  return 1'b0;
			default:  return 1'($urandom_range(1));
		endcase
	endfunction

	// A tick with random content; the SDA level follows the chosen drive.
	function automatic tick_t random_tick(input sda_drive_t mode);
		tick_t t;
		t.cmd_valid = 1'($urandom_range(1));
		t.opcode    = 3'($urandom_range(7));
		t.tx_byte   = 8'($urandom_range(255));
		t.send_ack  = 1'($urandom_range(1));
		t.sda_in    = sda_for(mode);
		return t;
	endfunction

	// Offer one tick, wait for its transfer, then predict its result.
	task automatic send_tick(input tick_t t);
		lines_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata  <= {2'b00, t};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		step_bus_sequencer(t, res);
		predicted_lines_q.push_back(res);
		if (res.ack_failed)
			ack_failures++;
	endtask

	task automatic stop_offer();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// An idle tick that must leave the sequencer idle: no command, or an unknown opcode.
	task automatic send_ignored_tick(input logic offer, input logic [2:0] bad_op);
		tick_t t;
		t = random_tick(SDA_RAND);
		t.cmd_valid = offer;
		if (offer)
			t.opcode = bad_op;
		send_tick(t);
	endtask

	// Issue one command and keep ticking, with ignored noise, until it has finished.
	task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input sda_drive_t mode);
		tick_t t;
		t = random_tick(mode);
		t.cmd_valid = 1'b1;
		t.opcode    = op;
		t.tx_byte   = tx;
		t.send_ack  = ack;
		send_tick(t);
		commands_issued++;
		counted_ticks++;
		while (seq_phase != PH_IDLE) begin
			send_tick(random_tick(mode));
			counted_ticks++;
		end
	endtask

	// Bring the sequencer to idle and let every outstanding result drain.
	task automatic wait_idle();
		while (seq_phase != PH_IDLE)
			send_tick(random_tick(SDA_RAND));
		stop_offer();
		while (predicted_lines_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HALF_PERIOD)
			half_period_q = value;
		else
			ack_timeout_q = value[7:0];
		config_writes++;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] half, input logic [7:0] tmo);
		wait_idle();
		write_reg(REG_HALF_PERIOD, half);
		write_reg(REG_ACK_TIMEOUT, {8'h00, tmo});
	endtask

	// Short commands under the reset settings, with unknown opcodes while idle.
	task automatic test_basic_commands();
		send_idle_pct = 11;
		recv_idle_pct = 61;
		repeat (3) send_ignored_tick(1'b0, OP_START);
		for (int op = OP_READ + 1; op < 8; op++)
			send_ignored_tick(1'b1, 3'(op));
		run_command(OP_START, 8'h00, 1'b0, SDA_RAND);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
		run_command(OP_WAIT_ACK, 8'hFF, 1'b1, SDA_RAND);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND);
	endtask

	// A zero half period acts as one tick; a zero tolerance fails on the first high poll.
	task automatic test_zero_settings();
		configure(16'd0, 8'd0);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
		run_command(OP_START, 8'h00, 1'b0, SDA_RAND);
		run_command(OP_WRITE, 8'h96, 1'b0, SDA_RAND);
		run_command(OP_READ, 8'h00, 1'b0, SDA_RAND);
	endtask

	// Acknowledge tolerance at one and at its largest value.
	task automatic test_timeout_extremes();
		configure(16'd1, 8'd1);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_RAND);
		configure(16'd1, 8'hFF);
		run_command(OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
		run_command(OP_READ, 8'h00, 1'b1, SDA_RAND);
	endtask

	// Random command sequences with noise, over three idling patterns and random settings.
	task automatic test_random_traffic();
		int chunk_end;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 61 : 0;
			recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 11 : 0;
			configure(16'($urandom_range(3, 1)), 8'($urandom_range(12, 1)));
			chunk_end = counted_ticks + CHUNK_TICKS;
			while (counted_ticks < chunk_end) begin
				if ($urandom_range(99) < 10)
					send_ignored_tick(1'($urandom_range(1)),
						3'($urandom_range(7, OP_READ + 1)));
				else
					run_command(3'($urandom_range(OP_READ)), 8'($urandom_range(255)),
						1'($urandom_range(1)), sda_drive_t'($urandom_range(SDA_LOW)));
			end
		end
	endtask

	// The receiver holds off for a long stretch while ticks keep being offered.
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(16'd1, 8'd4);
		hold_req = 1'b1;
		run_command(OP_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RAND);
		run_command(OP_READ, 8'h00, 1'($urandom_range(1)), SDA_RAND);
	endtask

	// One start condition with a long half period, then a stop under the reset settings.
	task automatic test_long_half_period();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(16'd24, 8'hFF);
		run_command(OP_START, 8'h00, 1'b0, SDA_RAND);
		configure(HALF_PERIOD_RST, ACK_TIMEOUT_RST);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND);
	endtask

	// Receiver: random tready, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Each result transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_lines = lines_t'(m_axis_tdata[13:0]);
			if (predicted_lines_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("Result %h arrived with no prediction waiting", m_axis_tdata);
				mismatch_count++;
			end else begin
				want_lines = predicted_lines_q.pop_front();
				if (seen_lines.scl !== want_lines.scl
						|| seen_lines.sda_out !== want_lines.sda_out
						|| seen_lines.sda_oe !== want_lines.sda_oe
						|| seen_lines.busy !== want_lines.busy
						|| seen_lines.done !== want_lines.done
						|| seen_lines.rx_byte !== want_lines.rx_byte
						|| seen_lines.ack_failed !== want_lines.ack_failed) begin
					if (mismatch_count < 10) begin
						$display("Mismatch at result %0d: expected scl=%b sda=%b oe=%b busy=%b done=%b rx=%h fail=%b",
							results_checked, want_lines.scl, want_lines.sda_out,
							want_lines.sda_oe, want_lines.busy, want_lines.done,
							want_lines.rx_byte, want_lines.ack_failed);
						$display("  got scl=%b sda=%b oe=%b busy=%b done=%b rx=%h fail=%b",
							seen_lines.scl, seen_lines.sda_out, seen_lines.sda_oe,
							seen_lines.busy, seen_lines.done, seen_lines.rx_byte,
							seen_lines.ack_failed);
					end
					mismatch_count++;
				end
				results_checked++;
			end
		end
	end

	// Watchdog on cycles in which neither stream makes a transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		reset_prediction();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_commands();
		test_zero_settings();
		test_timeout_extremes();
		test_random_traffic();
		test_output_stall();
		test_long_half_period();
		wait_idle();
		$display("Ran %0d commands over %0d busy ticks, %0d of them ending in acknowledge timeout,",
			commands_issued, counted_ticks, ack_failures);
		$display("with %0d register writes and %0d result transfers compared.",
			config_writes, results_checked);
		if (mismatch_count == 0 && predicted_lines_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/i2cmbs_pkg.sv
design/i2c_master_bit_sequencer_unit.sv
tb/tb_top.sv
